### rtl/core/apsp_pkg.sv
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared widths, operation codes and types of the all-pairs shortest path block.
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 6;
    localparam int DIST_W   = 32;
    localparam int VC_W     = 7;

    localparam int MAX_VERTICES_DEF = 64;

    localparam logic [VC_W-1:0]   VC_RESET    = 7'd64;
    localparam logic [DIST_W-1:0] UNREACHABLE = 32'd99999;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Control of the pivot-row chain: shift every cell by one place and
    // feed the given word in at the tail.
    typedef struct packed {
        logic              shift;
        logic [DIST_W-1:0] tail_data;
    } chain_ctrl_t;

endpackage

### rtl/core/apsp_if.sv
// ----------------------------------------------------------------------------
// apsp_if
// Valid/ready channels of the all-pairs shortest path block.
// ----------------------------------------------------------------------------
interface apsp_cmd_if import apsp_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [IDX_W-1:0]         src;
    logic [IDX_W-1:0]         dst;
    logic signed [DIST_W-1:0] weight;

    modport source (output valid, operation, src, dst, weight, input ready);
    modport sink   (input valid, operation, src, dst, weight, output ready);
endinterface

interface apsp_result_if import apsp_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [DIST_W-1:0] distance;

    modport source (output valid, kind, distance, input ready);
    modport sink   (input valid, kind, distance, output ready);
endinterface

interface apsp_cfg_if import apsp_pkg::*;;
    logic            valid;
    logic            ready;
    logic [VC_W-1:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

### rtl/core/apsp_cell.sv
// ----------------------------------------------------------------------------
// apsp_cell
// One place of the pivot-row chain; holds one distance word.
// ----------------------------------------------------------------------------
module apsp_cell import apsp_pkg::*;
(
    input  logic              clk,
    input  chain_ctrl_t       ctrl,
    input  logic              is_tail,
    input  logic [DIST_W-1:0] from_next,
    output logic [DIST_W-1:0] value
);

    logic [DIST_W-1:0] value_reg;
    logic [DIST_W-1:0] value_next;

    // The tail cell takes the fed word, every other cell takes its neighbor's.
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = is_tail ? ctrl.tail_data : from_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

### rtl/core/all_pairs_shortest_path.sv
// ----------------------------------------------------------------------------
// all_pairs_shortest_path
// Distance matrix with edge write, read, clear and Floyd-Warshall compute.
// ----------------------------------------------------------------------------
// Usage: commands arrive on cmd as valid/ready beats carrying operation, src,
// dst and weight. A write edge stores weight at (src, dst) and a clear resets
// the matrix; neither returns a beat. A read returns one beat of kind 1 with
// the stored distance, and a compute returns one beat of kind 0 when done.
// The user writes the vertex_count register on cfg only while the block is
// idle; the block itself does not enforce this. The matrix lives in one
// memory with one write and one read port. A compute loads the pivot row k
// into a chain of cells, then for every row i reads d[i][k] once and streams
// d[i][j] past the chain head, one relaxation per cycle. A clear writes
// every one of the MAX_VERTICES^2 entries (rounded up to a power of four)
// while cmd is held not ready.
// After reset the same clearing pass runs before the first command is taken.
// A finished result waits in an output register; while the receiver stalls
// the block still accepts a write, clear or config beat, and starts a further
// read or compute, which then waits for the output register to drain.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path import apsp_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    apsp_cmd_if.sink      cmd,
    apsp_result_if.source result,
    apsp_cfg_if.sink      cfg
);

    localparam int IW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_RDATA = 4'd3;
    localparam logic [3:0] ST_LOADB = 4'd4;
    localparam logic [3:0] ST_LOADA = 4'd5;
    localparam logic [3:0] ST_RELAX = 4'd6;
    localparam logic [3:0] ST_DRAIN = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam logic [1:0] TAG_LOADB = 2'd0;
    localparam logic [1:0] TAG_LOADA = 2'd1;
    localparam logic [1:0] TAG_RELAX = 2'd2;

    // Configuration register and the effective vertex count derived from it.
    logic [VC_W-1:0] vc_reg;
    logic [NW-1:0]   n_eff;
    logic [NW-1:0]   n_last;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VC_RESET;
        end
        else if (cfg.valid)
        begin
            vc_reg <= cfg.vertex_count;
        end
    end

    assign n_eff  = (32'(vc_reg) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vc_reg);
    assign n_last = n_eff - NW'(1);

    // Sequencer registers.
    logic [3:0]        state_reg, state_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [IW-1:0]     k_reg, k_next;
    logic [IW-1:0]     i_reg, i_next;
    logic [IW-1:0]     j_reg, j_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic              oor_reg, oor_next;

    // Second stage of the compute pipe: tag of the word now on the read port.
    logic              s1_valid_reg, s1_valid_next;
    logic [1:0]        s1_tag_reg, s1_tag_next;
    logic              s1_jk_reg, s1_jk_next;
    logic              s1_krow_reg, s1_krow_next;

    // Memory and its ports.
    logic [DIST_W-1:0] mem [DEPTH];
    logic [DIST_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DIST_W-1:0] wr_data;

    logic [DIST_W-1:0] a_reg, a_next;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [DIST_W-1:0] out_dist_reg, out_dist_next;
    logic              out_free;

    // Pivot-row chain.
    chain_ctrl_t       chain_ctrl;
    logic [DIST_W-1:0] cell_value [MAX_VERTICES];

    logic              cmd_fire;
    logic              in_range;
    logic              j_last, i_last, k_last;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign in_range  = (32'(cmd.src) < 32'(n_eff)) && (32'(cmd.dst) < 32'(n_eff));
    assign j_last    = (NW'(j_reg) == n_last);
    assign i_last    = (NW'(i_reg) == n_last);
    assign k_last    = (NW'(k_reg) == n_last);
    assign out_free  = !out_valid_reg || result.ready;

    // Relaxation in the second stage: a = d[i][k], b = d[k][j] at the chain
    // head, c = d[i][j] from memory. Sums are 33 bits wide and only saturate
    // downward, since an upward overflow never beats a 32-bit value.
    logic signed [DIST_W:0] sum;
    logic                   relax_ok;
    logic                   take;
    logic [DIST_W-1:0]      relaxed;
    logic [DIST_W-1:0]      b_head;

    assign b_head   = cell_value[0];
    assign sum      = $signed({a_reg[DIST_W-1], a_reg}) + $signed({b_head[DIST_W-1], b_head});
    assign relax_ok = (a_reg != UNREACHABLE) && (b_head != UNREACHABLE);
    assign take     = s1_valid_reg && (s1_tag_reg == TAG_RELAX) && relax_ok
                      && (sum < $signed({rd_data_reg[DIST_W-1], rd_data_reg}));
    assign relaxed  = (sum[DIST_W:DIST_W-1] == 2'b10) ? {1'b1, {(DIST_W-1){1'b0}}}
                                                       : sum[DIST_W-1:0];

    // Chain: loads shift memory words in, relaxations rotate the row and put
    // back the updated word while the pivot row itself is being relaxed.
    always_comb
    begin
        chain_ctrl.shift     = 1'b0;
        chain_ctrl.tail_data = rd_data_reg;
        if (s1_valid_reg && (s1_tag_reg == TAG_LOADB))
        begin
            chain_ctrl.shift = 1'b1;
        end
        else if (s1_valid_reg && (s1_tag_reg == TAG_RELAX))
        begin
            chain_ctrl.shift     = 1'b1;
            chain_ctrl.tail_data = (take && s1_krow_reg) ? relaxed : b_head;
        end
    end

    for (genvar g = 0; g < MAX_VERTICES; g++)
    begin : g_cell
        localparam int NEXT = (g == MAX_VERTICES - 1) ? g : g + 1;
        logic [DIST_W-1:0] from_next;
        assign from_next = (g == MAX_VERTICES - 1) ? chain_ctrl.tail_data : cell_value[NEXT];

        apsp_cell u_cell
        (
            .clk       (clk),
            .ctrl      (chain_ctrl),
            .is_tail   (NW'(g) == n_last),
            .from_next (from_next),
            .value     (cell_value[g])
        );
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        rd_addr_next  = rd_addr_reg;
        oor_next      = oor_reg;
        s1_valid_next = 1'b0;
        s1_tag_next   = s1_tag_reg;
        s1_jk_next    = s1_jk_reg;
        s1_krow_next  = s1_krow_reg;
        rd_en         = 1'b0;
        rd_addr       = rd_addr_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_kind_next  = out_kind_reg;
        out_dist_next  = out_dist_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd.operation)
                        OP_WRITE:
                        begin
                            state_next = ST_IDLE;
                        end
                        OP_COMPUTE:
                        begin
                            k_next = '0;
                            i_next = '0;
                            j_next = '0;
                            state_next = (n_eff == '0) ? ST_DONE : ST_LOADB;
                        end
                        OP_READ:
                        begin
                            rd_addr_next = {IW'(cmd.src), IW'(cmd.dst)};
                            oor_next     = !in_range;
                            state_next   = ST_RD;
                        end
                        OP_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_RDATA;
            end
            ST_RDATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_READ;
                    out_dist_next  = oor_reg ? UNREACHABLE : rd_data_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_LOADB:
            begin
                rd_en         = 1'b1;
                rd_addr       = {k_reg, j_reg};
                s1_valid_next = 1'b1;
                s1_tag_next   = TAG_LOADB;
                if (j_last)
                begin
                    j_next     = '0;
                    i_next     = '0;
                    state_next = ST_LOADA;
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
            end
            ST_LOADA:
            begin
                rd_en         = 1'b1;
                rd_addr       = {i_reg, k_reg};
                s1_valid_next = 1'b1;
                s1_tag_next   = TAG_LOADA;
                j_next        = '0;
                state_next    = ST_RELAX;
            end
            ST_RELAX:
            begin
                rd_en         = 1'b1;
                rd_addr       = {i_reg, j_reg};
                s1_valid_next = 1'b1;
                s1_tag_next   = TAG_RELAX;
                s1_jk_next    = (j_reg == k_reg);
                s1_krow_next  = (i_reg == k_reg);
                if (!j_last)
                begin
                    j_next = j_reg + IW'(1);
                end
                else if (!i_last)
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_LOADA;
                end
                else if (!k_last)
                begin
                    k_next     = k_reg + IW'(1);
                    j_next     = '0;
                    state_next = ST_LOADB;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_DONE;
                    out_dist_next  = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The write port serves the clearing pass, edge writes and relaxations;
    // these never overlap in time.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {i_reg, j_reg};
        wr_data = relaxed;
        a_next  = a_reg;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_reg;
            wr_data = (sweep_reg[AW-1:IW] == sweep_reg[IW-1:0]) ? '0 : UNREACHABLE;
        end
        else if (cmd_fire && (cmd.operation == OP_WRITE))
        begin
            wr_en   = in_range;
            wr_addr = {IW'(cmd.src), IW'(cmd.dst)};
            wr_data = cmd.weight;
        end
        else if (take)
        begin
            // The relaxed entry is the one issued in the previous cycle, which is the
            // previous column of the current row.
            wr_en   = 1'b1;
            wr_addr = {i_reg, j_reg - IW'(1)};
            if (state_reg != ST_RELAX)
            begin
                wr_addr = {i_reg, n_last[IW-1:0]};
            end
        end

        if (s1_valid_reg && (s1_tag_reg == TAG_LOADA))
        begin
            a_next = rd_data_reg;
        end
        else if (take && s1_jk_reg)
        begin
            a_next = relaxed;
        end
    end

    // Second-stage write address: tracked directly to stay clear of the
    // counter moves above.
    logic [AW-1:0] s1_addr_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[(take && !(state_reg == ST_CLEAR)
                 && !(cmd_fire && (cmd.operation == OP_WRITE))) ? s1_addr_reg : wr_addr]
                <= wr_data;
        end
        s1_addr_reg  <= rd_addr;
        a_reg        <= a_next;
        out_kind_reg <= out_kind_next;
        out_dist_reg <= out_dist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            rd_addr_reg   <= '0;
            oor_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_tag_reg    <= TAG_LOADB;
            s1_jk_reg     <= 1'b0;
            s1_krow_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            rd_addr_reg   <= rd_addr_next;
            oor_reg       <= oor_next;
            s1_valid_reg  <= s1_valid_next;
            s1_tag_reg    <= s1_tag_next;
            s1_jk_reg     <= s1_jk_next;
            s1_krow_reg   <= s1_krow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.kind     = out_kind_reg;
    assign result.distance = out_dist_reg;

`ifndef SYNTH
    // The compute pipe is empty whenever a new command can be taken.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !s1_valid_reg)
        else $error("compute pipe not drained in idle");

    // A result beat only appears out of the read-data or done state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RDATA || $past(state_reg) == ST_DONE))
        else $error("result beat raised outside a finishing state");

    // No relaxation writes while the clearing pass owns the write port.
    a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !take)
        else $error("relaxation write during clearing pass");
`endif

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the all-pairs shortest path block.
// A scoreboard class keeps its own distance matrix and vertex count. It works
// out the beat each command should return: the done beat of a compute, or the
// distance of a read. Commands run in phases, and each phase sets its own
// vertex count, the extremes among them. Random idling on both channels and
// one long receiver stall put backpressure on the block.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apsp_pkg::*;

    localparam int NV         = MAX_VERTICES_DEF;
    localparam int CYCLE_CAP  = 4000000;
    localparam int CLEAR_WAIT = 5000;

    typedef struct {
        logic                     kind;
        logic signed [DIST_W-1:0] distance;
    } path_beat_t;

    // The scoreboard keeps a copy of the matrix and the vertex count. It also
    // keeps a queue of the beats still owed by the block.
    class path_scoreboard;
        logic signed [DIST_W-1:0] dmat [NV][NV];
        logic [VC_W-1:0]          vcount;
        path_beat_t               owed [$];
        int                       errors;
        int                       checked;

        function new();
            vcount  = VC_RESET;
            errors  = 0;
            checked = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < NV; i++)
                for (int j = 0; j < NV; j++)
                    dmat[i][j] = (i == j) ? '0 : UNREACHABLE;
        endfunction

        function int live_count();
            return (vcount > NV) ? NV : int'(vcount);
        endfunction

        // Floyd-Warshall over the live vertices. Operands that are unreachable
        // are skipped. Sums are kept wide, so a win below the 32-bit range
        // saturates to the most negative value.
        function void relax(int n);
            longint a;
            longint b;
            longint c;
            longint s;
            for (int k = 0; k < n; k++)
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                    begin
                        a = dmat[i][k];
                        b = dmat[k][j];
                        c = dmat[i][j];
                        if (a == 99999 || b == 99999)
                            continue;
                        s = a + b;
                        if (s < c)
                            dmat[i][j] = (s < -64'sd2147483648) ? 32'h8000_0000 : s[31:0];
                    end
        endfunction

        function void note_command(logic [OP_W-1:0] op, int s, int d,
                                   logic signed [DIST_W-1:0] w);
            path_beat_t b;
            int n;
            n = live_count();
            case (op)
                OP_WRITE:
                    if (s < n && d < n)
                        dmat[s][d] = w;
                OP_COMPUTE:
                begin
                    relax(n);
                    b.kind = KIND_DONE;
                    b.distance = '0;
                    owed.push_back(b);
                end
                OP_READ:
                begin
                    b.kind = KIND_READ;
                    b.distance = (s < n && d < n) ? dmat[s][d] : UNREACHABLE;
                    owed.push_back(b);
                end
                default:
                    wipe();
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic kind, logic signed [DIST_W-1:0] distance);
            path_beat_t b;
            checked++;
            if (owed.size() == 0)
            begin
                report($sformatf("unexpected beat kind=%0d distance=%0d", kind, distance));
                return;
            end
            b = owed.pop_front();
            if (kind !== b.kind)
                report($sformatf("kind %0d, expected %0d", kind, b.kind));
            if (distance !== b.distance)
                report($sformatf("distance %0d, expected %0d", distance, b.distance));
        endtask
    endclass

    logic clk;
    logic rst_n;

    apsp_cmd_if    cmd ();
    apsp_result_if result ();
    apsp_cfg_if    cfg ();

    all_pairs_shortest_path dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    path_scoreboard sb;

    // These knobs are set by the main sequence and read by the command and result processes.
    bit cmd_idle_on;
    bit res_idle_on;
    int res_hold;
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // This is the watchdog. It counts clock cycles and stops a run that hangs.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // This is the result side. Before each beat it waits a random number of
    // cycles, and when a long hold is requested it waits that out instead.
    // Values are sampled just after the edge, so they are the ones the DUT
    // saw at that edge.
    initial
    begin
        int gap;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = res_idle_on ? $urandom_range(0, 16) : 0;
            if (res_hold > 0)
            begin
                gap = res_hold;
                res_hold = 0;
            end
            if (gap > 0)
            begin
                result.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result.valid);
            sb.check_result(result.kind, result.distance);
        end
    end

    // This sends one command beat, after a random gap when idling is on.
    // The valid line stays high from one beat to the next when there is no
    // gap between them.
    task automatic send(logic [OP_W-1:0] op, int s, int d, logic signed [DIST_W-1:0] w);
        int gap;
        gap = cmd_idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.operation <= op;
        cmd.src       <= s[IDX_W-1:0];
        cmd.dst       <= d[IDX_W-1:0];
        cmd.weight    <= w;
        do
            @(posedge clk);
        while (!cmd.ready);
        sb.note_command(op, s, d, w);
    endtask

    // This drops valid and waits until every owed beat has come back.
    task automatic drain();
        cmd.valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
    endtask

    // The register is written only while the block is idle. A clear returns
    // no beat but keeps the block busy for a full matrix pass, so the bench
    // also waits that long before it writes.
    task automatic set_vertex_count(logic [VC_W-1:0] value);
        drain();
        repeat (CLEAR_WAIT) @(posedge clk);
        cfg.valid        <= 1'b1;
        cfg.vertex_count <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        sb.vcount = value;
    endtask

    // This picks a weight: mostly small values that make real paths, with
    // some "no edge" markers, the extremes, and full 32-bit noise.
    function automatic logic signed [DIST_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return UNREACHABLE;
            1:       return 32'sh8000_0000;
            2:       return 32'sh7fff_ffff;
            3:       return $urandom();
            default: return $urandom_range(0, 120) - 20;
        endcase
    endfunction

    // This picks a vertex index. Most indices fall inside the live count, and
    // the rest span the whole field, so out-of-range cases get tested too.
    function automatic int pick_index(int n);
        if (n > 0 && $urandom_range(0, 4) != 0)
            return $urandom_range(0, n - 1);
        return $urandom_range(0, NV - 1);
    endfunction

    // This runs a random stretch of commands. A compute over the full
    // matrix is left out when every vertex is live.
    task automatic random_run(int beats);
        int n;
        int pick;
        n = sb.live_count();
        for (int b = 0; b < beats; b++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
                send(OP_WRITE, pick_index(n), pick_index(n), pick_weight());
            else if (pick < 11 && n < NV)
                send(OP_COMPUTE, $urandom_range(0, NV - 1), $urandom_range(0, NV - 1), $urandom());
            else if (pick < 19)
                send(OP_READ, pick_index(n), pick_index(n), $urandom());
            else
                send(OP_CLEAR, $urandom_range(0, NV - 1), $urandom_range(0, NV - 1), $urandom());
        end
    endtask

    initial
    begin
        logic [VC_W-1:0] counts [9];
        sb = new();
        counts = '{7'd3, 7'd1, 7'd0, 7'd8, 7'd100, 7'd5, 7'd2, 7'd6, 7'd127};
        cmd_idle_on = 1'b1;
        res_idle_on = 1'b1;
        res_hold    = 0;

        rst_n            = 1'b0;
        cmd.valid        <= 1'b0;
        cmd.operation    <= OP_WRITE;
        cmd.src          <= '0;
        cmd.dst          <= '0;
        cmd.weight       <= '0;
        cfg.valid        <= 1'b0;
        cfg.vertex_count <= VC_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first phase is directed and keeps the reset count of 64. It
        // reads the reset matrix at and near its corners, writes the extreme weights,
        // and runs one full-size compute. In that compute, a chain of the
        // most negative weight and a small negative one must saturate.
        send(OP_READ, 0, 0, 0);
        send(OP_READ, 63, 62, 0);
        send(OP_WRITE, 63, 0, 32'sh7fff_ffff);
        send(OP_READ, 63, 0, 0);
        send(OP_WRITE, 0, 63, 32'sh8000_0000);
        send(OP_READ, 0, 63, 0);
        send(OP_CLEAR, 0, 0, 0);
        send(OP_READ, 63, 0, 0);
        send(OP_WRITE, 0, 1, 32'sh8000_0000);
        send(OP_WRITE, 1, 2, -5);
        send(OP_WRITE, 2, 3, UNREACHABLE);
        send(OP_WRITE, 3, 4, 7);
        send(OP_WRITE, 4, 5, 32'sh7fff_ffff);
        send(OP_COMPUTE, 0, 0, 0);
        send(OP_READ, 0, 2, 0);
        send(OP_READ, 3, 5, 0);
        send(OP_READ, 2, 4, 0);

        // The next phases each set a new vertex count. The list covers one
        // vertex, no vertex, the top count, and counts that saturate.
        for (int p = 0; p < 9; p++)
        begin
            set_vertex_count(counts[p]);
            cmd_idle_on = (p % 3) != 1;
            res_idle_on = (p % 4) != 2;
            if (counts[p] == 7'd0)
            begin
                send(OP_COMPUTE, 0, 0, 0);
                send(OP_WRITE, 0, 0, 5);
                send(OP_READ, 0, 0, 0);
            end
            if (counts[p] == 7'd8)
            begin
                // The result side stalls for a long stretch. The command
                // side keeps sending at full rate, so the block must fill up
                // and stop taking commands.
                cmd_idle_on = 1'b0;
                res_hold = 400;
                random_run(12);
            end
            else
                random_run(9);
            if (counts[p] == 7'd5)
            begin
                // The command side pauses mid-phase until every owed beat
                // has come back, then goes on.
                drain();
                random_run(4);
            end
        end

        drain();
        repeat (100) @(posedge clk);
        $display("covered: %0d result beats over 10 vertex-count phases, ranging 0 to 127",
                 sb.checked);
        $display("covered: saturating sums, out-of-range indices, clears, a long stall");
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
rtl/core/apsp_pkg.sv
rtl/core/apsp_if.sv
rtl/core/apsp_cell.sv
rtl/core/all_pairs_shortest_path.sv
bench/tb.sv
